// ===== rtl/core/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator package
// Character codes, operator kinds and operand codes shared by the design.
// ----------------------------------------------------------------------------
package iee_pkg;

    typedef logic [7:0] t_char;
    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_mulop;
    typedef logic [1:0] t_phase;

    localparam t_char CH_PLUS  = 8'h2B;
    localparam t_char CH_MINUS = 8'h2D;
    localparam t_char CH_STAR  = 8'h2A;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_ZERO  = 8'h30;
    localparam t_char CH_NINE  = 8'h39;
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;

    // what the held character does once its factor or term is closed
    localparam t_kind K_OTHER = 3'd0;
    localparam t_kind K_ADD   = 3'd1;
    localparam t_kind K_SUB   = 3'd2;
    localparam t_kind K_MUL   = 3'd3;
    localparam t_kind K_DIV   = 3'd4;

    localparam t_mulop OP_NONE = 2'd0;
    localparam t_mulop OP_MUL  = 2'd1;
    localparam t_mulop OP_DIV  = 2'd2;

    localparam t_phase PH_SKIP   = 2'd0;
    localparam t_phase PH_DIGITS = 2'd1;
    localparam t_phase PH_DONE   = 2'd2;

    localparam int unsigned OUT_WIDTH = 32;

endpackage

// ===== rtl/core/iee_if.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator channels
// Valid/ready channels for expression characters and evaluation results.
// ----------------------------------------------------------------------------
interface iee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       final_char;

    modport source (output valid, output character, output final_char, input ready);
    modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface iee_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               divide_by_zero;

    modport source (output valid, output value, output divide_by_zero, input ready);
    modport sink   (input valid, input value, input divide_by_zero, output ready);
endinterface

// ===== rtl/core/infix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// Infix expression evaluator
// Streams a parenthesis-free + - * / expression and returns its value.
// ----------------------------------------------------------------------------
// Characters arrive one per transfer; final_char marks the last one, and one
// result transfer follows it. A digit, whitespace or any other non-operator
// byte is taken in S_IDLE. An operator closes the open factor through S_FACTOR
// and S_APPLY, with a shift-add multiplication (S_MUL) or a restoring divide
// with sign fix-up (S_DNEGA, S_DNEGB, S_DIV, S_DFIX) between the two when the
// factor closes one; both run one bit per cycle through the single shared
// adder, and a zero divisor skips the divide. The final character closes the
// expression with the same sequence, run twice when it is itself an operator.
// Results wider than 32 bits are truncated, narrower ones sign-extended. The
// result is held in an output register, so the next expression may start
// while it waits.
// ----------------------------------------------------------------------------
module infix_expression_evaluator
    import iee_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iee_in_if.sink    i_in,
    iee_out_if.source o_out
);

    localparam int W  = WORD_WIDTH;
    localparam int CW = $clog2(W + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FACTOR = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DNEGA  = 3'd3;
    localparam logic [2:0] S_DNEGB  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_DFIX   = 3'd6;
    localparam logic [2:0] S_APPLY  = 3'd7;

    logic [2:0]    r_state;
    logic [W-1:0]  r_sum;
    logic          r_addneg;
    logic [W-1:0]  r_term;
    t_mulop        r_mulop;
    logic [W-1:0]  r_operand;
    t_phase        r_phase;
    logic          r_dz;
    t_kind         r_kind;
    logic          r_close;
    logic          r_final;
    logic          r_qneg;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_opa;   // multiplier, then dividend / quotient
    logic [W-1:0]  r_opb;   // multiplicand, then divisor magnitude
    logic [W-1:0]  r_rem;
    logic          r_out_valid;
    logic [31:0]   r_out_value;
    logic          r_out_dz;

    // shared adder
    logic [W:0]   add_a;
    logic [W:0]   add_b;
    logic         add_sub;
    logic [W+1:0] add_res;

    logic         in_xfer;
    logic         out_free;
    t_char        ch;
    t_kind        in_kind;
    logic         is_digit;
    logic         is_ws;
    logic [W-1:0] digit_next;
    logic [W:0]   div_shift;
    logic [31:0]  sum_ext;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign ch       = i_in.character;

    always_comb begin
        case (ch)
            CH_PLUS:  in_kind = K_ADD;
            CH_MINUS: in_kind = K_SUB;
            CH_STAR:  in_kind = K_MUL;
            CH_SLASH: in_kind = K_DIV;
            default:  in_kind = K_OTHER;
        endcase
    end

    assign is_digit   = (ch inside {[CH_ZERO:CH_NINE]});
    assign is_ws      = (ch == CH_SPACE) || (ch inside {[CH_TAB:CH_CR]});
    assign digit_next = (r_operand << 3) + (r_operand << 1)
                        + {{(W-4){1'b0}}, ch[3:0]};
    assign div_shift  = {r_rem, r_opa[W-1]};

    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                add_a = {1'b0, r_term};
                add_b = r_opa[0] ? {1'b0, r_opb} : '0;
            end
            S_DNEGA: begin
                add_b   = {1'b0, r_term};
                add_sub = r_term[W-1];
            end
            S_DNEGB: begin
                add_b   = {1'b0, r_operand};
                add_sub = r_operand[W-1];
            end
            S_DIV: begin
                add_a   = div_shift;
                add_b   = {1'b0, r_opb};
                add_sub = 1'b1;
            end
            S_DFIX: begin
                add_b   = {1'b0, r_opa};
                add_sub = r_qneg;
            end
            S_APPLY: begin
                add_a   = {1'b0, r_sum};
                add_b   = {1'b0, r_term};
                add_sub = r_addneg;
            end
            default: begin
                add_a = '0;
            end
        endcase
    end

    assign add_res = {1'b0, add_a} + ({1'b0, add_b} ^ {(W+2){add_sub}})
                     + {{(W+1){1'b0}}, add_sub};

    generate
        if (W >= OUT_WIDTH) begin : g_trunc
            assign sum_ext = add_res[OUT_WIDTH-1:0];
        end else begin : g_sext
            assign sum_ext = {{(OUT_WIDTH-W){add_res[W-1]}}, add_res[W-1:0]};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_addneg    <= 1'b0;
            r_term      <= '0;
            r_mulop     <= OP_NONE;
            r_operand   <= '0;
            r_phase     <= PH_SKIP;
            r_dz        <= 1'b0;
            r_kind      <= K_OTHER;
            r_close     <= 1'b0;
            r_final     <= 1'b0;
            r_qneg      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_kind  <= in_kind;
                        r_final <= i_in.final_char;
                        r_close <= (in_kind == K_ADD) || (in_kind == K_SUB)
                                   || (in_kind == K_OTHER);
                        if (in_kind == K_OTHER) begin
                            if (r_phase == PH_SKIP || r_phase == PH_DIGITS) begin
                                if (is_digit) begin
                                    r_operand <= digit_next;
                                    r_phase   <= PH_DIGITS;
                                end else if (!(is_ws && r_phase == PH_SKIP)) begin
                                    r_phase <= PH_DONE;
                                end
                            end
                            if (i_in.final_char) begin
                                r_state <= S_FACTOR;
                            end
                        end else begin
                            r_state <= S_FACTOR;
                        end
                    end
                end
                S_FACTOR: begin
                    case (r_mulop)
                        OP_MUL: begin
                            r_opa   <= r_operand;
                            r_opb   <= r_term;
                            r_term  <= '0;
                            r_cnt   <= CW'(W);
                            r_state <= S_MUL;
                        end
                        OP_DIV: begin
                            if (r_operand == '0) begin
                                r_term  <= '0;
                                r_dz    <= 1'b1;
                                r_state <= S_APPLY;
                            end else begin
                                r_qneg  <= r_term[W-1] ^ r_operand[W-1];
                                r_state <= S_DNEGA;
                            end
                        end
                        default: begin
                            r_term  <= r_operand;
                            r_state <= S_APPLY;
                        end
                    endcase
                end
                S_MUL: begin
                    r_term <= add_res[W-1:0];
                    r_opa  <= r_opa >> 1;
                    r_opb  <= r_opb << 1;
                    r_cnt  <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_DNEGA: begin
                    r_opa   <= add_res[W-1:0];
                    r_state <= S_DNEGB;
                end
                S_DNEGB: begin
                    r_opb   <= add_res[W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= CW'(W);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // borrow clear: the divisor fits, take the difference
                    r_rem <= add_res[W+1] ? div_shift[W-1:0] : add_res[W-1:0];
                    r_opa <= {r_opa[W-2:0], !add_res[W+1]};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_DFIX;
                    end
                end
                S_DFIX: begin
                    r_term  <= add_res[W-1:0];
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    if (r_final && r_kind == K_OTHER) begin
                        // closing term of the expression: hand out the sum
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_value <= sum_ext;
                            r_out_dz    <= r_dz;
                            r_sum       <= '0;
                            r_addneg    <= 1'b0;
                            r_term      <= '0;
                            r_mulop     <= OP_NONE;
                            r_operand   <= '0;
                            r_phase     <= PH_SKIP;
                            r_dz        <= 1'b0;
                            r_final     <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_operand <= '0;
                        r_phase   <= PH_SKIP;
                        if (r_close) begin
                            r_sum   <= add_res[W-1:0];
                            r_term  <= '0;
                            r_mulop <= OP_NONE;
                        end
                        case (r_kind)
                            K_ADD:   r_addneg <= 1'b0;
                            K_SUB:   r_addneg <= 1'b1;
                            K_MUL:   r_mulop  <= OP_MUL;
                            K_DIV:   r_mulop  <= OP_DIV;
                            default: r_addneg <= r_addneg;
                        endcase
                        if (r_final) begin
                            // last character was an operator: close once more
                            r_kind  <= K_OTHER;
                            r_close <= 1'b1;
                            r_state <= S_FACTOR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.value          = r_out_value;
    assign o_out.divide_by_zero = r_out_dz;

endmodule
